// ===== rtl/core/sdtp_pkg.sv =====
// Shared types and constants for the two-pass standard deviation block.
package sdtp_pkg;

   localparam int MAX_SAMPLES_DEFAULT = 256;
   localparam int SAMPLE_BITS_DEFAULT = 24;
   localparam int DEV_W  = 24;
   localparam int MEAN_W = 24;
   localparam int SQ_W   = 56;
   localparam int TOT_W  = 9;
   localparam int STAT_W = 2;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_ONE_SAMP = 2'd2,
      STAT_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MEAN,
      BK_SQ_RD,
      BK_SQ_ACC,
      BK_DIV,
      BK_SQRT,
      BK_DONE
   } back_state_type;

endpackage

// ===== rtl/core/sdtp_front.sv =====
// Front part: accepts samples, stores them, keeps count, sum and overflow flag.
module sdtp_front #(
   parameter int MAX_SAMPLES = sdtp_pkg::MAX_SAMPLES_DEFAULT,
   parameter int SAMPLE_BITS = sdtp_pkg::SAMPLE_BITS_DEFAULT,
   parameter int CNT_W = $clog2(MAX_SAMPLES + 1),
   parameter int ADR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
   parameter int SUM_W = SAMPLE_BITS + CNT_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [23:0]            in_sample,
   input  logic                   in_last,
   // job handed to back part
   output logic                   job_valid,
   input  logic                   job_ready,
   output logic [CNT_W-1:0]       job_count,
   output logic [SUM_W-1:0]       job_sum,
   output logic                   job_ovf,
   // memory read port for back part
   input  logic [ADR_W-1:0]       rd_addr,
   output logic [SAMPLE_BITS-1:0] rd_data
);

   logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             ovf_ff, ovf_in;
   logic             job_ff, job_in;
   logic             busy_ff, busy_in;
   logic [SAMPLE_BITS-1:0] x;
   logic             acc, full;

   assign x        = in_sample[SAMPLE_BITS-1:0];
   assign full     = (count_ff == CNT_W'(MAX_SAMPLES));
   // hold off new samples while the back part still reads this set
   assign in_ready = !job_ff && !busy_ff;
   assign acc      = in_valid && in_ready;
   assign job_valid = job_ff;
   assign job_count = count_ff;
   assign job_sum   = sum_ff;
   assign job_ovf   = ovf_ff;

   // store the sample and register the read data
   always_ff @(posedge clock) begin
      if (acc && !full) begin
         mem[count_ff[ADR_W-1:0]] <= x;
      end
      rd_data <= mem[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      job_in   = job_ff;
      busy_in  = busy_ff;
      if (acc) begin
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + SUM_W'(x);
         end else begin
            ovf_in = 1'b1;
         end
         if (in_last) job_in = 1'b1;
      end
      if (job_ff && job_ready) begin
         job_in  = 1'b0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         job_ff   <= 1'b0;
         busy_ff  <= 1'b0;
      end else if (busy_ff && job_ready) begin
         // back part is done with the set: clear it
         count_ff <= '0;
         sum_ff   <= '0;
         ovf_ff   <= 1'b0;
         busy_ff  <= 1'b0;
         job_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         ovf_ff   <= ovf_in;
         job_ff   <= job_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

// ===== rtl/core/sdtp_back.sv =====
// Back part: mean, squared-deviation pass, divide and square root.
module sdtp_back #(
   parameter int MAX_SAMPLES = sdtp_pkg::MAX_SAMPLES_DEFAULT,
   parameter int SAMPLE_BITS = sdtp_pkg::SAMPLE_BITS_DEFAULT,
   parameter int CNT_W = $clog2(MAX_SAMPLES + 1),
   parameter int ADR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
   parameter int SUM_W = SAMPLE_BITS + CNT_W
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_mode,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  logic [CNT_W-1:0]       job_count,
   input  logic [SUM_W-1:0]       job_sum,
   input  logic                   job_ovf,
   output logic [ADR_W-1:0]       rd_addr,
   input  logic [SAMPLE_BITS-1:0] rd_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [23:0]            out_dev,
   output logic [23:0]            out_mean,
   output logic [55:0]            out_sq,
   output logic [8:0]             out_total,
   output logic [1:0]             out_status
);

   localparam int SQ_W = sdtp_pkg::SQ_W;
   localparam int PW   = 2 * SAMPLE_BITS;
   localparam int DW   = SQ_W;

   sdtp_pkg::back_state_type st_ff, st_in;

   logic [CNT_W-1:0]       idx_ff;
   logic                   ph_ff;
   logic [SUM_W-1:0]       rem_ff;
   logic [SUM_W-1:0]       q_ff;
   logic [6:0]             step_ff;
   logic [SAMPLE_BITS-1:0] mean_ff;
   logic [PW-1:0]          prod_ff;
   logic [SQ_W-1:0]        sq_ff;
   logic [DW-1:0]          dq_ff, drem_ff;
   logic [CNT_W-1:0]       div_ff;
   logic [SQ_W-1:0]        rt_ff, rv_ff;
   logic [SQ_W+1:0]        rrem_ff;
   logic                   ov_ff, ovalid_ff;
   logic [23:0]            dev_ff, mean_o_ff;
   logic [55:0]            sq_o_ff;
   logic [8:0]             tot_ff;
   logic [1:0]             stat_ff;

   logic [SAMPLE_BITS-1:0] d;
   logic [SUM_W:0]         rsh;
   logic [DW:0]            dsh;
   logic [SQ_W+1:0]        trial;
   logic [SQ_W+1:0]        rrsh;
   logic [SQ_W:0]          sqsum;
   logic                   finish;

   assign out_valid  = ovalid_ff;
   assign out_dev    = dev_ff;
   assign out_mean   = mean_o_ff;
   assign out_sq     = sq_o_ff;
   assign out_total  = tot_ff;
   assign out_status = stat_ff;
   assign rd_addr    = idx_ff[ADR_W-1:0];
   assign finish     = (st_ff == sdtp_pkg::BK_DONE) && (!ovalid_ff || out_ready);
   assign job_ready  = (st_ff == sdtp_pkg::BK_IDLE) || finish;

   assign d     = (rd_data >= mean_ff) ? rd_data - mean_ff : mean_ff - rd_data;
   assign rsh   = {rem_ff, job_sum[SUM_W-1-step_ff[5:0]]};
   assign dsh   = {drem_ff, dq_ff[DW-1]};
   assign rrsh  = {rrem_ff[SQ_W-1:0], rv_ff[SQ_W-1 -: 2]};
   assign trial = {rt_ff, 2'b01};
   assign sqsum = {1'b0, sq_ff} + (SQ_W+1)'(prod_ff);

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         sdtp_pkg::BK_IDLE:   if (job_valid) st_in = sdtp_pkg::BK_MEAN;
         sdtp_pkg::BK_MEAN:   if (step_ff == 7'(SUM_W - 1)) st_in = sdtp_pkg::BK_SQ_RD;
         sdtp_pkg::BK_SQ_RD:  if (idx_ff == job_count) st_in = sdtp_pkg::BK_DIV;
                              else if (ph_ff) st_in = sdtp_pkg::BK_SQ_ACC;
         sdtp_pkg::BK_SQ_ACC: st_in = sdtp_pkg::BK_SQ_RD;
         sdtp_pkg::BK_DIV:    if (step_ff == 7'(DW - 1)) st_in = sdtp_pkg::BK_SQRT;
         sdtp_pkg::BK_SQRT:   if (step_ff == 7'(SQ_W/2 - 1)) st_in = sdtp_pkg::BK_DONE;
         sdtp_pkg::BK_DONE:   if (finish) st_in = job_valid ? sdtp_pkg::BK_MEAN
                                                           : sdtp_pkg::BK_IDLE;
         default:             st_in = sdtp_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= sdtp_pkg::BK_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (finish) ovalid_ff <= 1'b1;
         else if (out_ready) ovalid_ff <= 1'b0;
      end
   end

   // datapath per state
   always_ff @(posedge clock) begin
      unique case (st_ff)
         sdtp_pkg::BK_IDLE, sdtp_pkg::BK_DONE: begin
            step_ff <= '0;
            rem_ff  <= '0;
            q_ff    <= '0;
            idx_ff  <= '0;
            ph_ff   <= 1'b0;
            // hold the sum while a finished result waits for capture
            if (st_ff == sdtp_pkg::BK_IDLE || finish) sq_ff <= '0;
            ov_ff   <= job_ovf;
         end
         // restoring divide of sum by count, one bit a cycle
         sdtp_pkg::BK_MEAN: begin
            if (job_count != '0 && rsh >= (SUM_W+1)'(job_count)) begin
               rem_ff <= SUM_W'(rsh - (SUM_W+1)'(job_count));
               q_ff   <= {q_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= rsh[SUM_W-1:0];
               q_ff   <= {q_ff[SUM_W-2:0], 1'b0};
            end
            step_ff <= (step_ff == 7'(SUM_W - 1)) ? 7'd0 : step_ff + 7'd1;
         end
         // read address issued, then data arrives in the next cycle
         sdtp_pkg::BK_SQ_RD: begin
            if (step_ff == 7'd0) mean_ff <= SAMPLE_BITS'(q_ff);
            if (idx_ff == job_count) begin
               step_ff <= '0;
               dq_ff   <= DW'(sq_ff);
               drem_ff <= '0;
               div_ff  <= pop_mode ? job_count : job_count - CNT_W'(1);
            end else if (ph_ff) begin
               step_ff <= 7'd1;
               prod_ff <= PW'(d) * PW'(d);
            end else begin
               step_ff <= 7'd1;
               ph_ff   <= 1'b1;
            end
         end
         sdtp_pkg::BK_SQ_ACC: begin
            sq_ff  <= sqsum[SQ_W] ? '1 : sqsum[SQ_W-1:0];
            idx_ff <= idx_ff + CNT_W'(1);
            ph_ff  <= 1'b0;
         end
         sdtp_pkg::BK_DIV: begin
            if (div_ff != '0 && dsh >= (DW+1)'(div_ff)) begin
               drem_ff <= DW'(dsh - (DW+1)'(div_ff));
               dq_ff   <= {dq_ff[DW-2:0], 1'b1};
            end else begin
               drem_ff <= dsh[DW-1:0];
               dq_ff   <= {dq_ff[DW-2:0], 1'b0};
            end
            if (step_ff == 7'(DW - 1)) begin
               step_ff <= '0;
               rt_ff   <= '0;
               rrem_ff <= '0;
            end else begin
               step_ff <= step_ff + 7'd1;
            end
         end
         // digit-by-digit square root, two bits a cycle
         sdtp_pkg::BK_SQRT: begin
            if (step_ff == 7'd0) begin
               rv_ff   <= {dq_ff[SQ_W-3:0], 2'b00};
               rrem_ff <= (dq_ff[SQ_W-1 -: 2] != 2'b00)
                          ? (SQ_W+2)'(dq_ff[SQ_W-1 -: 2]) - (SQ_W+2)'(1) : '0;
               rt_ff   <= (dq_ff[SQ_W-1 -: 2] != 2'b00) ? SQ_W'(1) : '0;
            end else begin
               rv_ff <= {rv_ff[SQ_W-3:0], 2'b00};
               if (rrsh >= trial) begin
                  rrem_ff <= rrsh - trial;
                  rt_ff   <= {rt_ff[SQ_W-2:0], 1'b1};
               end else begin
                  rrem_ff <= rrsh;
                  rt_ff   <= {rt_ff[SQ_W-2:0], 1'b0};
               end
            end
            step_ff <= step_ff + 7'd1;
         end
         default: ;
      endcase
      // capture result
      if (finish) begin
         tot_ff <= 9'(job_count);
         if (job_count == '0) begin
            dev_ff <= '0; sq_o_ff <= '0; mean_o_ff <= '0;
            stat_ff <= sdtp_pkg::STAT_EMPTY;
         end else if (div_ff == '0) begin
            dev_ff <= '0; sq_o_ff <= '0;
            mean_o_ff <= 24'(mean_ff);
            stat_ff <= sdtp_pkg::STAT_ONE_SAMP;
         end else begin
            mean_o_ff <= 24'(mean_ff);
            dev_ff  <= (rt_ff > SQ_W'(24'hFFFFFF)) ? 24'hFFFFFF : rt_ff[23:0];
            sq_o_ff <= 56'(sq_ff);
            stat_ff <= ov_ff ? sdtp_pkg::STAT_OVERFLOW : sdtp_pkg::STAT_OK;
         end
      end
   end

endmodule

// ===== rtl/core/standard_deviation_two_pass.sv =====
// Top level of the two-pass standard deviation block.
// Flow: after the last sample transfer, 33 mean-divide steps, a second pass that
// reads, squares and accumulates each stored sample, then 56 divide and 28
// square-root steps run before rsp_valid rises.
// Throughput: one sample per cycle in a set; the next set waits until the
// result is captured, which also waits while an earlier result is not taken.
// Reset: synchronous, clears counts, sums and handshake state; mode goes to 1.
module standard_deviation_two_pass #(
   parameter int MAX_SAMPLES = sdtp_pkg::MAX_SAMPLES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_sample_value,
   input  logic        req_last_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_std_deviation,
   output logic [23:0] rsp_mean_value,
   output logic [55:0] rsp_sum_of_squares,
   output logic [8:0]  rsp_sample_total,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   localparam int SAMPLE_BITS = sdtp_pkg::SAMPLE_BITS_DEFAULT;
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int ADR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int SUM_W = SAMPLE_BITS + CNT_W;

   logic                   mode_ff;
   logic                   job_valid, job_ready, job_ovf;
   logic [CNT_W-1:0]       job_count;
   logic [SUM_W-1:0]       job_sum;
   logic [ADR_W-1:0]       rd_addr;
   logic [SAMPLE_BITS-1:0] rd_data;

   // hold the mode register
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b1;
      else if (csr_write_enable) mode_ff <= csr_write_data;
   end

   sdtp_front #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready),
      .in_sample(req_sample_value), .in_last(req_last_sample),
      .job_valid, .job_ready, .job_count, .job_sum, .job_ovf,
      .rd_addr, .rd_data
   );

   sdtp_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock, .reset, .pop_mode(mode_ff),
      .job_valid, .job_ready, .job_count, .job_sum, .job_ovf,
      .rd_addr, .rd_data,
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_dev(rsp_std_deviation), .out_mean(rsp_mean_value),
      .out_sq(rsp_sum_of_squares), .out_total(rsp_sample_total),
      .out_status(rsp_status)
   );

`ifndef SYNTH
   a_no_accept_during_job: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> !req_ready) else $error("sample accepted while set pending");
   a_status_ok_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sdtp_pkg::STAT_EMPTY |-> rsp_sample_total == 9'd0)
      else $error("empty status with nonzero total");
   a_one_samp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sdtp_pkg::STAT_ONE_SAMP |-> rsp_std_deviation == 24'd0)
      else $error("one-sample status with nonzero deviation");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the two-pass standard deviation block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   class sd_scoreboard;
      bit [23:0] stored[$];
      bit [31:0] acc_sum;
      bit        dropped;
      bit        pop_mode;
      bit [114:0] pending_results[$];
      int         errors;
      int         checked;

      function new();
         acc_sum  = 0;
         dropped  = 0;
         pop_mode = 1;
         errors   = 0;
         checked  = 0;
      endfunction

      function bit [63:0] isqrt(bit [63:0] v);
         bit [63:0] root;
         bit [63:0] b;
         root = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= root + b) begin
               v = v - (root + b);
               root = (root >> 1) + b;
            end else begin
               root = root >> 1;
            end
            b = b >> 2;
         end
         return root;
      endfunction

      // Note one accepted sample; on the marked one, predict the result.
      function void note_sample(bit [23:0] x, bit last);
         bit [63:0] mean;
         bit [63:0] sq;
         bit [63:0] d;
         bit [63:0] p;
         bit [63:0] dev;
         bit [63:0] div;
         bit [1:0]  st;
         bit [63:0] lim;
         lim = 64'h00FF_FFFF_FFFF_FFFF;
         if (stored.size() < 256) begin
            stored.insert(stored.size(), x);
            acc_sum = acc_sum + x;
         end else begin
            dropped = 1;
         end
         if (!last) return;
         mean = acc_sum / stored.size();
         sq = 0;
         foreach (stored[i]) begin
            d = (stored[i] >= mean) ? stored[i] - mean : mean - stored[i];
            p = d * d;
            if (p > lim || sq > lim - p) sq = lim;
            else sq = sq + p;
         end
         div = pop_mode ? stored.size() : stored.size() - 1;
         if (div == 0) begin
            st = sdtp_pkg::STAT_ONE_SAMP;
            sq = 0;
            dev = 0;
         end else begin
            dev = isqrt(sq / div);
            if (dev > 64'hFF_FFFF) dev = 64'hFF_FFFF;
            st = dropped ? sdtp_pkg::STAT_OVERFLOW : sdtp_pkg::STAT_OK;
         end
         pending_results.insert(pending_results.size(),
                                {dev[23:0], mean[23:0], sq[55:0],
                                 9'(stored.size()), st});
         stored.delete();
         acc_sum = 0;
         dropped = 0;
      endfunction

      task report(string what, bit [63:0] got, bit [63:0] want);
         errors++;
         $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      endtask

      // Compare one result transfer with the oldest prediction.
      task check_result(bit [23:0] dev, bit [23:0] mean, bit [55:0] sq,
                        bit [8:0] tot, bit [1:0] st);
         bit [114:0] w;
         checked++;
         if (pending_results.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
         end
         w = pending_results.pop_front();
         if (dev  != w[114:91]) report("std_deviation", dev, w[114:91]);
         if (mean != w[90:67])  report("mean_value", mean, w[90:67]);
         if (sq   != w[66:11])  report("sum_of_squares", sq, w[66:11]);
         if (tot  != w[10:2])   report("sample_total", tot, w[10:2]);
         if (st   != w[1:0])    report("status", st, w[1:0]);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [23:0] req_sample_value = 0;
   logic        req_last_sample = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [23:0] rsp_std_deviation;
   logic [23:0] rsp_mean_value;
   logic [55:0] rsp_sum_of_squares;
   logic [8:0]  rsp_sample_total;
   logic [1:0]  rsp_status;
   logic        csr_write_enable = 0;
   logic        csr_write_data = 0;

   sd_scoreboard sb = new();
   bit  idle_on = 1;
   int  cycle_count = 0;
   int  sets_done = 0;
   int  samples_sent = 0;
   localparam int CYCLE_LIMIT = 2_000_000;

   standard_deviation_two_pass u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_value(req_sample_value), .req_last_sample(req_last_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_std_deviation(rsp_std_deviation), .rsp_mean_value(rsp_mean_value),
      .rsp_sum_of_squares(rsp_sum_of_squares), .rsp_sample_total(rsp_sample_total),
      .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: while idle_on, stall in random bursts; check each result transfer.
   initial begin : result_side
      int stall;
      @(posedge clock);
      while (1) begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(1, 17);
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_std_deviation, rsp_mean_value, rsp_sum_of_squares,
                            rsp_sample_total, rsp_status);
      end
   end

   // Send one sample; hold valid until the transfer.
   task automatic send_sample(bit [23:0] x, bit last);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1;
      req_sample_value <= x;
      req_last_sample <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(x, last);
      samples_sent++;
      if (last) sets_done++;
   endtask

   // Wait until every prediction is consumed, then write the mode.
   task automatic set_mode(bit m);
      req_valid <= 0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.pop_mode = m;
   endtask

   function automatic bit [23:0] rand_sample(int kind);
      case (kind)
         0: return 24'hFF_FFFF;
         1: return 24'h0;
         2: return 24'(32'h80_0000 + $urandom_range(0, 255));
         default: return 24'($urandom());
      endcase
   endfunction

   task automatic send_set(int n, int kind);
      for (int i = 0; i < n; i++)
         send_sample(kind == 4 ? rand_sample($urandom_range(0, 3)) : rand_sample(kind),
                     i == n - 1);
   endtask

   initial begin : stimulus
      int n;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: single samples in both modes, extremes, alternating extremes.
      send_set(1, 0);
      send_set(2, 0);
      send_sample(24'h0, 0);
      send_sample(24'hFF_FFFF, 0);
      send_sample(24'h0, 0);
      send_sample(24'hFF_FFFF, 1);
      send_set(3, 1);
      set_mode(0);
      send_set(1, 3);
      send_set(2, 3);
      send_sample(24'hFF_FFFF, 0);
      send_sample(24'h0, 1);
      set_mode(1);
      // Full store, then overflow with the marked item dropped.
      send_set(256, 4);
      send_set(258, 0);
      set_mode(0);
      send_set(260, 4);
      // Random sets, mostly small, mode changing between phases.
      while (samples_sent < 1700) begin
         if ($urandom_range(0, 9) == 0) set_mode(1'($urandom_range(0, 1)));
         if (samples_sent > 1400) idle_on = 0;
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 262)
                                          : $urandom_range(1, 12);
         send_set(n, $urandom_range(0, 4));
      end
      req_valid <= 0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("covered %0d samples in %0d sets, both modes, store full and overflow",
               samples_sent, sets_done);
      $display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ===== standard_deviation_two_pass.f =====
rtl/core/sdtp_pkg.sv
rtl/core/sdtp_front.sv
rtl/core/sdtp_back.sv
rtl/core/standard_deviation_two_pass.sv
sim/tb_top.sv
